@@ rtl/touch_press_qualifier_core_macros.svh @@
// ----------------------------------------------------------------------------
// touch_press_qualifier_core assertion macros
// Clocked implication helpers with active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef TOUCH_PRESS_QUALIFIER_CORE_MACROS_SVH
`define TOUCH_PRESS_QUALIFIER_CORE_MACROS_SVH

// Same-cycle implication.
`define TPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("touch_press_qualifier_core: assertion failed");

// Next-cycle implication.
`define TPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("touch_press_qualifier_core: assertion failed");

`endif

@@ rtl/tpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared widths, register map, reset values and bundle types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    localparam int TIME_W  = 32;
    localparam int RAW_W   = 12;
    localparam int CAL_W   = 16;
    localparam int THR_W   = 12;
    localparam int MS_W    = 16;
    localparam int SX_W    = 9;
    localparam int SY_W    = 8;

    localparam int SIZE_W  = 13;
    localparam int VAL_W   = 12;
    localparam int DIFF_W  = CAL_W + 1;
    localparam int DEN_W   = CAL_W + 1;
    localparam int NUM_W   = DIFF_W + SIZE_W + 1;
    localparam int CNT_W   = $clog2(NUM_W);

    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    localparam logic [IDX_W-1:0] REG_X_LO      = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_HI      = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_LO      = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_HI      = 3'd3;
    localparam logic [IDX_W-1:0] REG_PRESS_THR = 3'd4;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 3'd5;
    localparam logic [IDX_W-1:0] REG_RELEASE   = 3'd6;

    localparam logic [CAL_W-1:0] RST_X_LO      = 16'd200;
    localparam logic [CAL_W-1:0] RST_X_HI      = 16'd3700;
    localparam logic [CAL_W-1:0] RST_Y_LO      = 16'd240;
    localparam logic [CAL_W-1:0] RST_Y_HI      = 16'd3800;
    localparam logic [THR_W-1:0] RST_PRESS_THR = 12'd400;
    localparam logic [MS_W-1:0]  RST_DEBOUNCE  = 16'd150;
    localparam logic [MS_W-1:0]  RST_RELEASE   = 16'd60;

    typedef struct packed {
        logic [CAL_W-1:0] x_lo;
        logic [CAL_W-1:0] x_hi;
        logic [CAL_W-1:0] y_lo;
        logic [CAL_W-1:0] y_hi;
        logic [THR_W-1:0] pressure_threshold;
        logic [MS_W-1:0]  debounce_ms;
        logic [MS_W-1:0]  release_ms;
    } t_cfg;

    typedef struct packed {
        logic             press;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

@@ rtl/tpq_front.sv @@
// ----------------------------------------------------------------------------
// tpq_front
// Request qualifier: pen/release tracking, pressure and debounce gating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpq_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire tpq_pkg::t_cfg              i_cfg,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [tpq_pkg::TIME_W-1:0] i_now_ms,
    input  wire logic                       i_pen_touched,
    input  wire logic [tpq_pkg::RAW_W-1:0]  i_raw_x,
    input  wire logic [tpq_pkg::RAW_W-1:0]  i_raw_y,
    input  wire logic [tpq_pkg::RAW_W-1:0]  i_pressure,
    input  wire tpq_pkg::t_q_status         i_q_status,
    output logic                            o_push,
    output tpq_pkg::t_job                   o_job
);

    logic                       r_pen_down, n_pen_down;
    logic                       r_reported, n_reported;
    logic                       r_pending,  n_pending;
    logic [tpq_pkg::TIME_W-1:0] r_rel_start, n_rel_start;
    logic [tpq_pkg::TIME_W-1:0] r_last_press, n_last_press;
    logic [tpq_pkg::TIME_W-1:0] w_rel_elapsed;
    logic [tpq_pkg::TIME_W-1:0] w_press_elapsed;
    logic                       w_accept;
    logic                       w_press;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    assign w_rel_elapsed   = i_now_ms - r_rel_start;
    assign w_press_elapsed = i_now_ms - r_last_press;

    always_comb begin
        n_pen_down   = r_pen_down;
        n_reported   = r_reported;
        n_pending    = r_pending;
        n_rel_start  = r_rel_start;
        n_last_press = r_last_press;
        w_press      = 1'b0;
        if (!i_pen_touched) begin
            if (r_pen_down || r_reported) begin
                if (!r_pending) begin
                    n_pending   = 1'b1;
                    n_rel_start = i_now_ms;
                end else if (w_rel_elapsed >=
                             {{(tpq_pkg::TIME_W-tpq_pkg::MS_W){1'b0}}, i_cfg.release_ms}) begin
                    n_pen_down = 1'b0;
                    n_reported = 1'b0;
                    n_pending  = 1'b0;
                end
            end
        end else begin
            n_pending = 1'b0;
            if (i_pressure >= i_cfg.pressure_threshold && !r_reported &&
                !(r_pen_down && w_press_elapsed <
                  {{(tpq_pkg::TIME_W-tpq_pkg::MS_W){1'b0}}, i_cfg.debounce_ms})) begin
                w_press      = 1'b1;
                n_pen_down   = 1'b1;
                n_reported   = 1'b1;
                n_last_press = i_now_ms;
            end
        end
    end

    assign o_push      = w_accept;
    assign o_job.press = w_press;
    assign o_job.raw_x = i_raw_x;
    assign o_job.raw_y = i_raw_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_down   <= 1'b0;
            r_reported   <= 1'b0;
            r_pending    <= 1'b0;
            r_rel_start  <= '0;
            r_last_press <= '0;
        end else if (w_accept) begin
            r_pen_down   <= n_pen_down;
            r_reported   <= n_reported;
            r_pending    <= n_pending;
            r_rel_start  <= n_rel_start;
            r_last_press <= n_last_press;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tpq_queue.sv @@
// ----------------------------------------------------------------------------
// tpq_queue
// Two-entry job queue between the qualifier and the mapping engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpq_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tpq_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output tpq_pkg::t_job       o_job,
    output tpq_pkg::t_q_status  o_status
);

    tpq_pkg::t_job r_mem [2];
    logic          r_wr_ptr, n_wr_ptr;
    logic          r_rd_ptr, n_rd_ptr;
    logic [1:0]    r_count,  n_count;
    logic          w_push;
    logic          w_pop;

    assign o_status.valid = (r_count != 2'd0);
    assign o_status.full  = (r_count == 2'd2);
    assign o_job          = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && o_status.valid;

    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop  ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tpq_map.sv @@
// ----------------------------------------------------------------------------
// tpq_map
// Linear calibration of one axis: multiply, restoring divide, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpq_map (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tpq_pkg::RAW_W-1:0]  i_raw,
    input  wire logic [tpq_pkg::CAL_W-1:0]  i_lo,
    input  wire logic [tpq_pkg::CAL_W-1:0]  i_hi,
    input  wire logic [tpq_pkg::SIZE_W-1:0] i_size,
    output logic                            o_done,
    output logic [tpq_pkg::VAL_W-1:0]       o_value
);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } t_map_state;

    localparam int NW = tpq_pkg::NUM_W;
    localparam int DW = tpq_pkg::DEN_W;
    localparam int FW = tpq_pkg::DIFF_W;

    t_map_state                r_state;
    logic [tpq_pkg::CNT_W-1:0] r_cnt;
    logic signed [FW-1:0]      r_diff;
    logic signed [FW-1:0]      r_span;
    logic [NW-1:0]             r_num;
    logic [DW-1:0]             r_den;
    logic [DW-1:0]             r_rem;
    logic                      r_neg;
    logic                      r_zero;
    logic                      r_done;
    logic [tpq_pkg::VAL_W-1:0] r_value;

    logic signed [NW-1:0]       w_prod;
    logic [NW-1:0]              w_prod_mag;
    logic [DW-1:0]              w_span_mag;
    logic [DW:0]                w_rem_sh;
    logic [DW:0]                w_rem_sub;
    logic                       w_ge;
    logic [NW-1:0]              w_quot;
    logic [tpq_pkg::SIZE_W-1:0] w_limit;
    logic [tpq_pkg::VAL_W-1:0]  w_clamped;

    assign w_prod = $signed({{(NW-FW){r_diff[FW-1]}}, r_diff}) *
                    $signed({{(NW-tpq_pkg::SIZE_W){1'b0}}, i_size});
    assign w_prod_mag = w_prod[NW-1] ? NW'(-w_prod) : NW'(w_prod);
    assign w_span_mag = r_span[FW-1] ? DW'(-r_span) : DW'(r_span);

    assign w_rem_sh  = {r_rem, r_num[NW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};
    assign w_quot    = {r_num[NW-2:0], w_ge};
    assign w_limit   = i_size - tpq_pkg::SIZE_W'(1);

    always_comb begin
        if (r_zero || r_neg) begin
            w_clamped = '0;
        end else if (w_quot > {{(NW-tpq_pkg::SIZE_W){1'b0}}, w_limit}) begin
            w_clamped = w_limit[tpq_pkg::VAL_W-1:0];
        end else begin
            w_clamped = w_quot[tpq_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == M_DIV) && (r_cnt == tpq_pkg::CNT_W'(NW - 1));
            case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_diff  <= $signed({{(FW-tpq_pkg::RAW_W){1'b0}}, i_raw}) -
                                   $signed({i_lo[tpq_pkg::CAL_W-1], i_lo});
                        r_span  <= $signed({i_hi[tpq_pkg::CAL_W-1], i_hi}) -
                                   $signed({i_lo[tpq_pkg::CAL_W-1], i_lo});
                        r_state <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_num   <= w_prod_mag;
                    r_den   <= w_span_mag;
                    r_rem   <= '0;
                    r_neg   <= r_diff[FW-1] ^ r_span[FW-1];
                    r_zero  <= (r_span == '0);
                    r_cnt   <= '0;
                    r_state <= M_DIV;
                end
                M_DIV: begin
                    r_rem <= w_ge ? w_rem_sub[DW-1:0] : w_rem_sh[DW-1:0];
                    r_num <= w_quot;
                    r_cnt <= r_cnt + tpq_pkg::CNT_W'(1);
                    if (r_cnt == tpq_pkg::CNT_W'(NW - 1)) begin
                        r_value <= w_clamped;
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

`default_nettype wire

@@ rtl/tpq_back.sv @@
// ----------------------------------------------------------------------------
// tpq_back
// Job executor: runs both axis maps for a press and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpq_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tpq_pkg::t_cfg            i_cfg,
    input  wire tpq_pkg::t_job            i_job,
    input  wire tpq_pkg::t_q_status       i_q_status,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_press_valid,
    output logic [tpq_pkg::SX_W-1:0]      o_screen_x,
    output logic [tpq_pkg::SY_W-1:0]      o_screen_y
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_WAIT,
        B_HOLD
    } t_back_state;

    t_back_state               r_state;
    logic                      r_out_valid;
    logic                      r_press;
    logic [tpq_pkg::SX_W-1:0]  r_sx;
    logic [tpq_pkg::SY_W-1:0]  r_sy;
    logic [tpq_pkg::SX_W-1:0]  r_hold_x;
    logic [tpq_pkg::SY_W-1:0]  r_hold_y;

    logic                      w_slot_free;
    logic                      w_start;
    logic                      w_load;
    logic                      w_done_x;
    logic                      w_done_y;
    logic [tpq_pkg::VAL_W-1:0] w_val_x;
    logic [tpq_pkg::VAL_W-1:0] w_val_y;

    assign w_slot_free = !r_out_valid || i_ready;
    assign o_pop       = (r_state == B_IDLE) && i_q_status.valid &&
                         (i_job.press || w_slot_free);
    assign w_start     = o_pop && i_job.press;
    assign w_load      = ((r_state == B_IDLE) && o_pop && !i_job.press) ||
                         ((r_state == B_HOLD) && w_slot_free);

    tpq_map u_map_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_raw   (i_job.raw_x),
        .i_lo    (i_cfg.x_lo),
        .i_hi    (i_cfg.x_hi),
        .i_size  (tpq_pkg::SIZE_W'(tpq_pkg::SCREEN_WIDTH)),
        .o_done  (w_done_x),
        .o_value (w_val_x)
    );

    tpq_map u_map_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_raw   (i_job.raw_y),
        .i_lo    (i_cfg.y_lo),
        .i_hi    (i_cfg.y_hi),
        .i_size  (tpq_pkg::SIZE_W'(tpq_pkg::SCREEN_HEIGHT)),
        .o_done  (w_done_y),
        .o_value (w_val_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        if (i_job.press) begin
                            r_state <= B_WAIT;
                        end else begin
                            r_press <= 1'b0;
                            r_sx    <= '0;
                            r_sy    <= '0;
                        end
                    end
                end
                B_WAIT: begin
                    if (w_done_x && w_done_y) begin
                        r_hold_x <= w_val_x[tpq_pkg::SX_W-1:0];
                        r_hold_y <= w_val_y[tpq_pkg::SY_W-1:0];
                        r_state  <= B_HOLD;
                    end
                end
                B_HOLD: begin
                    if (w_slot_free) begin
                        r_press <= 1'b1;
                        r_sx    <= r_hold_x;
                        r_sy    <= r_hold_y;
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_press_valid = r_press;
    assign o_screen_x    = r_sx;
    assign o_screen_y    = r_sy;

endmodule

`default_nettype wire

@@ rtl/touch_press_qualifier_core.sv @@
// ----------------------------------------------------------------------------
// touch_press_qualifier_core
// Touch poll press qualifier with linear screen calibration.
//
//   channel   direction  handshake          payload
//   poll      in         i_valid/o_ready    i_now_ms i_pen_touched i_raw_x
//                                           i_raw_y i_pressure
//   result    out        o_valid/i_ready    o_press_valid o_screen_x o_screen_y
//   config    in         psel/penable/...   paddr pwdata prdata
//
// One result per request. A request with no press shows its result once it has
// passed the queue and the result register; a press shows it once the 31-step
// restoring divider in each axis map is done. The two axis maps run side by side.
// A two-entry queue lets polls be taken while the divider works or the result
// waits. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module touch_press_qualifier_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [tpq_pkg::TIME_W-1:0] i_now_ms,
    input  wire logic                       i_pen_touched,
    input  wire logic [tpq_pkg::RAW_W-1:0]  i_raw_x,
    input  wire logic [tpq_pkg::RAW_W-1:0]  i_raw_y,
    input  wire logic [tpq_pkg::RAW_W-1:0]  i_pressure,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic                            o_press_valid,
    output logic [tpq_pkg::SX_W-1:0]        o_screen_x,
    output logic [tpq_pkg::SY_W-1:0]        o_screen_y,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [tpq_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tpq_pkg::DATA_W-1:0] pwdata,
    output logic [tpq_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    tpq_pkg::t_cfg             r_cfg;
    tpq_pkg::t_job             w_push_job;
    tpq_pkg::t_job             w_head_job;
    tpq_pkg::t_q_status        w_q_status;
    logic                      w_push;
    logic                      w_pop;
    logic                      w_cfg_wr;
    logic [tpq_pkg::IDX_W-1:0] w_idx;

    assign pready   = 1'b1;
    assign w_idx    = paddr[tpq_pkg::ADDR_W-1:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_lo               <= tpq_pkg::RST_X_LO;
            r_cfg.x_hi               <= tpq_pkg::RST_X_HI;
            r_cfg.y_lo               <= tpq_pkg::RST_Y_LO;
            r_cfg.y_hi               <= tpq_pkg::RST_Y_HI;
            r_cfg.pressure_threshold <= tpq_pkg::RST_PRESS_THR;
            r_cfg.debounce_ms        <= tpq_pkg::RST_DEBOUNCE;
            r_cfg.release_ms         <= tpq_pkg::RST_RELEASE;
        end else if (w_cfg_wr) begin
            case (w_idx)
                tpq_pkg::REG_X_LO:      r_cfg.x_lo <= pwdata[tpq_pkg::CAL_W-1:0];
                tpq_pkg::REG_X_HI:      r_cfg.x_hi <= pwdata[tpq_pkg::CAL_W-1:0];
                tpq_pkg::REG_Y_LO:      r_cfg.y_lo <= pwdata[tpq_pkg::CAL_W-1:0];
                tpq_pkg::REG_Y_HI:      r_cfg.y_hi <= pwdata[tpq_pkg::CAL_W-1:0];
                tpq_pkg::REG_PRESS_THR: begin
                    r_cfg.pressure_threshold <= pwdata[tpq_pkg::THR_W-1:0];
                end
                tpq_pkg::REG_DEBOUNCE:  r_cfg.debounce_ms <= pwdata[tpq_pkg::MS_W-1:0];
                tpq_pkg::REG_RELEASE:   r_cfg.release_ms  <= pwdata[tpq_pkg::MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tpq_pkg::REG_X_LO:      prdata = tpq_pkg::DATA_W'(r_cfg.x_lo);
            tpq_pkg::REG_X_HI:      prdata = tpq_pkg::DATA_W'(r_cfg.x_hi);
            tpq_pkg::REG_Y_LO:      prdata = tpq_pkg::DATA_W'(r_cfg.y_lo);
            tpq_pkg::REG_Y_HI:      prdata = tpq_pkg::DATA_W'(r_cfg.y_hi);
            tpq_pkg::REG_PRESS_THR: prdata = tpq_pkg::DATA_W'(r_cfg.pressure_threshold);
            tpq_pkg::REG_DEBOUNCE:  prdata = tpq_pkg::DATA_W'(r_cfg.debounce_ms);
            tpq_pkg::REG_RELEASE:   prdata = tpq_pkg::DATA_W'(r_cfg.release_ms);
            default:                prdata = '0;
        endcase
    end

    tpq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_now_ms      (i_now_ms),
        .i_pen_touched (i_pen_touched),
        .i_raw_x       (i_raw_x),
        .i_raw_y       (i_raw_y),
        .i_pressure    (i_pressure),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    tpq_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    tpq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_job         (w_head_job),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_press_valid (o_press_valid),
        .o_screen_x    (o_screen_x),
        .o_screen_y    (o_screen_y)
    );

endmodule

`default_nettype wire

@@ rtl/tpq_checker.sv @@
// ----------------------------------------------------------------------------
// tpq_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "touch_press_qualifier_core_macros.svh"

module tpq_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       o_valid,
    input  wire logic                       i_ready,
    input  wire logic                       o_press_valid,
    input  wire logic [tpq_pkg::SX_W-1:0]   o_screen_x,
    input  wire logic [tpq_pkg::SY_W-1:0]   o_screen_y
);

    logic [tpq_pkg::SX_W+tpq_pkg::SY_W:0] w_payload;
    logic                                 w_stall;
    logic                                 w_x_ok;
    logic                                 w_y_ok;

    assign w_payload = {o_press_valid, o_screen_x, o_screen_y};
    assign w_stall   = o_valid && !i_ready;
    assign w_x_ok    = 32'(o_screen_x) < 32'(tpq_pkg::SCREEN_WIDTH);
    assign w_y_ok    = 32'(o_screen_y) < 32'(tpq_pkg::SCREEN_HEIGHT);

    `TPQ_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, w_stall, o_valid && $stable(w_payload))
    `TPQ_ASSERT_IMPLIES(a_idle_zero, i_clk, i_rst_n, o_valid && !o_press_valid, w_payload == '0)
    `TPQ_ASSERT_IMPLIES(a_x_range, i_clk, i_rst_n, o_valid, w_x_ok)
    `TPQ_ASSERT_IMPLIES(a_y_range, i_clk, i_rst_n, o_valid, w_y_ok)

endmodule

bind touch_press_qualifier_core tpq_checker u_tpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_press_valid (o_press_valid),
    .o_screen_x    (o_screen_x),
    .o_screen_y    (o_screen_y)
);

`default_nettype wire
